FILE: rtl/cle_pkg.sv
package cle_pkg;

   localparam int LINE_DEPTH = 32;
   localparam int ADDR_W = $clog2(LINE_DEPTH);
   localparam int WPOS_W = $clog2(LINE_DEPTH + 1);
   localparam int CHAR_W = 7;
   localparam int POS_W = 5;
   localparam int RX_W = 8;
   localparam int RSP_DATA_W = 16;

   localparam logic [RX_W-1:0] CODE_BS = 8'h08;
   localparam logic [RX_W-1:0] CODE_LF = 8'h0A;
   localparam logic [RX_W-1:0] CODE_CR = 8'h0D;
   localparam logic [RX_W-1:0] CODE_SPACE = 8'h20;
   localparam logic [RX_W-1:0] CODE_DEL = 8'h7F;

   localparam logic KIND_ECHO = 1'b0;
   localparam logic KIND_LINE = 1'b1;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [WPOS_W-1:0] wpos_type;
   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [POS_W-1:0] pos_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ECHO  = 4'b0010,
      S_RADDR = 4'b0100,
      S_RDATA = 4'b1000
   } state_type;

   typedef struct packed {
      logic kind;
      char_type char_out;
      pos_type position;
      logic last;
   } result_type;

   typedef struct packed {
      logic wr_en;
      addr_type wr_addr;
      char_type wr_data;
      logic rd_en;
      addr_type rd_addr;
   } ram_req_type;

   function automatic logic char_accepted(input logic [RX_W-1:0] c);
      return ((c >= CODE_BS) && (c <= CODE_CR)) || ((c >= CODE_SPACE) && (c <= CODE_DEL));
   endfunction

endpackage

FILE: rtl/cle_line_ram.sv
module cle_line_ram (
   input logic clock,
   input cle_pkg::ram_req_type ram_req,
   output cle_pkg::char_type rd_data
);
   import cle_pkg::*;

   char_type line_mem [LINE_DEPTH];
   char_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         line_mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      // read data holds while no read is issued
      if (ram_req.rd_en) begin
         rd_data_ff <= line_mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/cle_ctrl.sv
module cle_ctrl (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   input logic [cle_pkg::RX_W-1:0] req_tdata,
   input logic out_free,
   output cle_pkg::ram_req_type ram_req,
   input cle_pkg::char_type ram_rd_data,
   output logic result_valid,
   output cle_pkg::result_type result
);
   import cle_pkg::*;

   state_type state_ff, state_in;
   wpos_type wp_ff, wp_in;
   wpos_type len_ff, len_in;
   addr_type idx_ff, idx_in;
   char_type ch_ff, ch_in;
   logic lf_ff, lf_in;

   logic room;
   logic back;
   logic is_lf;
   logic echo;
   logic read_last;
   wpos_type wp_step;

   always_comb begin
      room = wp_ff < WPOS_W'(LINE_DEPTH);
      back = (req_tdata == CODE_BS) || (req_tdata == CODE_DEL);
      is_lf = req_tdata == CODE_LF;
      echo = room && (!back || (wp_ff != '0));
      if (!room) begin
         wp_step = wp_ff;
      end else if (back) begin
         wp_step = (wp_ff != '0) ? wp_ff - WPOS_W'(1) : wp_ff;
      end else begin
         wp_step = wp_ff + WPOS_W'(1);
      end
      read_last = (WPOS_W'(idx_ff) + WPOS_W'(1)) == len_ff;
   end

   always_comb begin
      state_in = state_ff;
      wp_in = wp_ff;
      len_in = len_ff;
      idx_in = idx_ff;
      ch_in = ch_ff;
      lf_in = lf_ff;
      req_tready = 1'b0;
      result_valid = 1'b0;
      result = '0;
      ram_req = '0;
      ram_req.wr_addr = wp_ff[ADDR_W-1:0];
      ram_req.wr_data = req_tdata[CHAR_W-1:0];
      ram_req.rd_addr = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && char_accepted(req_tdata)) begin
               ch_in = req_tdata[CHAR_W-1:0];
               lf_in = is_lf;
               ram_req.wr_en = room;
               wp_in = is_lf ? '0 : wp_step;
               len_in = wp_step;
               idx_in = '0;
               if (echo) begin
                  state_in = S_ECHO;
               end else if (is_lf) begin
                  state_in = S_RADDR;
               end
            end
         end
         S_ECHO: begin
            if (out_free) begin
               result_valid = 1'b1;
               result.kind = KIND_ECHO;
               result.char_out = ch_ff;
               result.position = '0;
               result.last = !lf_ff;
               state_in = lf_ff ? S_RADDR : S_IDLE;
            end
         end
         S_RADDR: begin
            ram_req.rd_en = 1'b1;
            state_in = S_RDATA;
         end
         S_RDATA: begin
            if (out_free) begin
               result_valid = 1'b1;
               result.kind = KIND_LINE;
               result.char_out = ram_rd_data;
               result.position = POS_W'(idx_ff);
               result.last = read_last;
               if (read_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + ADDR_W'(1);
                  state_in = S_RADDR;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wp_ff <= '0;
      end else begin
         state_ff <= state_in;
         wp_ff <= wp_in;
      end
      len_ff <= len_in;
      idx_ff <= idx_in;
      ch_ff <= ch_in;
      lf_ff <= lf_in;
   end

`ifndef SYNTHESIS
   a_wp_bound: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= WPOS_W'(LINE_DEPTH))
      else $error("write position past line depth");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      result_valid |-> out_free)
      else $error("result issued into a full output register");

   a_read_in_line: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RDATA) |-> (WPOS_W'(idx_ff) < len_ff))
      else $error("readout index beyond line length");

   a_wp_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RADDR || state_ff == S_RDATA) |-> (wp_ff == '0))
      else $error("write position not cleared during readout");
`endif

endmodule

FILE: rtl/console_line_editor_core.sv
// Line editor for a serial console.
// req_* carries received characters, one per item; codes outside 8..13 and
// 32..127 are dropped without a result. rsp_* carries results: tuser says
// echo (0) or completed-line character (1), tlast marks the final result
// of an input item.
// Each accepted character is written into a 32-entry line RAM and echoed.
// Backspace/delete echo only on a non-empty line; with the line full every
// character but a line feed is ignored. A line feed triggers a readout of the stored line.
// A plain character is accepted, then echoed into the output register. A
// line feed then reads out each stored character through an address state
// and a data state, since the line RAM read is registered.
// Input is not taken during echo or readout.
// Results sit in a single output register; the core keeps working while it
// is full and only stalls when the next result has nowhere to go.
// Reset (synchronous) empties the line; RAM contents are not cleared and
// need no clearing pass, since only entries of the current line are read.
module console_line_editor_core (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   input logic [cle_pkg::RX_W-1:0] req_tdata,   // [7:0] rx_char
   output logic rsp_tvalid,
   input logic rsp_tready,
   output logic [cle_pkg::RSP_DATA_W-1:0] rsp_tdata, // [6:0] char_out, [11:7] position
   output logic rsp_tuser,                      // [0] kind
   output logic rsp_tlast
);
   import cle_pkg::*;

   ram_req_type ram_req;
   char_type ram_rd_data;
   logic out_free;
   logic result_valid;
   result_type result;

   logic rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   cle_line_ram u_ram (
      .clock(clock),
      .ram_req(ram_req),
      .rd_data(ram_rd_data)
   );

   cle_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .out_free(out_free),
      .ram_req(ram_req),
      .ram_rd_data(ram_rd_data),
      .result_valid(result_valid),
      .result(result)
   );

   always_comb begin
      out_free = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (out_free) begin
         rsp_valid_in = result_valid;
         rsp_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {(RSP_DATA_W - POS_W - CHAR_W)'(0), rsp_ff.position, rsp_ff.char_out};
   assign rsp_tuser = rsp_ff.kind;
   assign rsp_tlast = rsp_ff.last;

`ifndef SYNTHESIS
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   a_no_input_on_result: assert property (@(posedge clock) disable iff (reset)
      result_valid |-> !req_tready)
      else $error("input taken while a result is issued");

   a_echo_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_ECHO)) |-> (rsp_tdata[11:7] == '0))
      else $error("echo result with nonzero position");
`endif

endmodule

FILE: tb/console_line_editor_core_test.sv
`timescale 1ns / 1ps

module console_line_editor_core_test;
   import cle_pkg::*;

   localparam logic [RX_W-1:0] CODE_HT = 8'h09;
   localparam logic [RX_W-1:0] CODE_VT = 8'h0B;
   localparam logic [RX_W-1:0] CODE_FF = 8'h0C;
   localparam int CYCLE_LIMIT = 600000;
   localparam int MAX_REPORTS = 10;
   localparam int RANDOM_ITEMS = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [RX_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;

   // predicted line contents and write position
   char_type line_buf [LINE_DEPTH];
   int line_len = 0;
   result_type echo_and_line_due [$];

   int fail_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   logic [15:0] ready_pattern = '1;

   console_line_editor_core u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // receiver stall pattern, chosen anew from four kinds; sometimes no stalls
   always @(posedge clock) begin
      if (cycle_count % 64 == 0) begin
         case ($urandom_range(3))
            0: ready_pattern = '1;
            1: ready_pattern = 16'($urandom | $urandom);
            2: ready_pattern = 16'($urandom);
            default: ready_pattern = 16'($urandom & $urandom);
         endcase
      end
      rsp_tready <= ready_pattern[cycle_count % 16];
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic result_type make_result(input logic kind, input char_type ch,
                                              input pos_type pos);
      result_type r;
      r.kind = kind;
      r.char_out = ch;
      r.position = pos;
      r.last = 1'b0;
      return r;
   endfunction

   // works out the echo and readout caused by one received character
   task automatic edit_line(input logic [RX_W-1:0] c);
      result_type caused [$];
      logic back;
      logic keep;
      keep = ((c >= CODE_BS) && (c <= CODE_CR)) || ((c >= CODE_SPACE) && (c <= CODE_DEL));
      back = (c == CODE_BS) || (c == CODE_DEL);
      if (keep) begin
         if (line_len < LINE_DEPTH) begin
            if (!back || line_len > 0)
               caused.push_back(make_result(KIND_ECHO, c[CHAR_W-1:0], '0));
            line_buf[line_len] = c[CHAR_W-1:0];
            if (back) begin
               if (line_len > 0) line_len--;
            end else begin
               line_len++;
            end
         end
         if (c == CODE_LF) begin
            for (int i = 0; i < line_len; i++)
               caused.push_back(make_result(KIND_LINE, line_buf[i], pos_type'(i)));
            line_len = 0;
         end
         if (caused.size() > 0) caused[caused.size()-1].last = 1'b1;
         foreach (caused[i]) echo_and_line_due.push_back(caused[i]);
      end
   endtask

   task automatic note_failure(input string what, input result_type want);
      if (fail_count < MAX_REPORTS)
         $display("%0d: %s: expected kind %0d char %h pos %0d last %0d, got kind %0d char %h pos %0d last %0d pad %h",
                  cycle_count, what, want.kind, want.char_out, want.position, want.last,
                  rsp_tuser, rsp_tdata[6:0], rsp_tdata[11:7], rsp_tlast, rsp_tdata[15:12]);
      fail_count++;
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (echo_and_line_due.size() == 0) begin
            want = '0;
            note_failure("unexpected item", want);
         end else begin
            want = echo_and_line_due.pop_front();
            if (rsp_tuser !== want.kind || rsp_tdata[6:0] !== want.char_out ||
                rsp_tdata[11:7] !== want.position || rsp_tlast !== want.last ||
                rsp_tdata[15:12] !== 4'b0000)
               note_failure("mismatch", want);
         end
      end
   end

   task automatic send_char(input logic [RX_W-1:0] c);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      edit_line(c);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      end
   endtask

   // hold off input until every predicted item has come out
   task automatic wait_line_drained();
      req_tvalid <= 1'b0;
      while (echo_and_line_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [RX_W-1:0] random_char();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) return ($urandom_range(1) == 0) ? CODE_BS : CODE_DEL;
      if (pick < 14) begin
         case ($urandom_range(3))
            0: return CODE_HT;
            1: return CODE_VT;
            2: return CODE_FF;
            default: return CODE_CR;
         endcase
      end
      return RX_W'($urandom_range(CODE_SPACE, CODE_DEL - 1));
   endfunction

   function automatic logic [RX_W-1:0] random_noise();
      case ($urandom_range(2))
         0: return RX_W'($urandom_range(0, CODE_BS - 1));
         1: return RX_W'($urandom_range(CODE_CR + 1, CODE_SPACE - 1));
         default: return RX_W'($urandom_range(CODE_DEL + 1, 255));
      endcase
   endfunction

   task automatic test_dropped_codes();
      logic [RX_W-1:0] codes [8] = '{8'h00, 8'h01, 8'h07, 8'h0E, 8'h1F, 8'h80, 8'hC5, 8'hFF};
      foreach (codes[i]) send_char(codes[i]);
      wait_line_drained();
   endtask

   task automatic test_editing_keys();
      // backspace and delete on an empty line give nothing
      send_char(CODE_BS);
      send_char(CODE_DEL);
      send_char(8'h41);
      send_char(CODE_SPACE);
      send_char(8'h7E);
      send_char(CODE_HT);
      send_char(CODE_VT);
      send_char(CODE_FF);
      send_char(CODE_CR);
      send_char(CODE_BS);
      send_char(CODE_DEL);
      send_char(8'h7A);
      send_char(CODE_LF);
      wait_line_drained();
   endtask

   task automatic test_empty_line();
      send_char(CODE_LF);
      send_char(CODE_BS);
      send_char(CODE_LF);
      wait_line_drained();
   endtask

   task automatic test_full_line();
      // line feed lands in the last free entry
      repeat (LINE_DEPTH - 1) send_char(RX_W'($urandom_range(CODE_SPACE, CODE_DEL - 1)));
      send_char(CODE_LF);
      // fill the store; after that everything is ignored and the line feed reads out without echo
      repeat (LINE_DEPTH) send_char(RX_W'($urandom_range(CODE_SPACE, CODE_DEL - 1)));
      send_char(CODE_BS);
      send_char(CODE_DEL);
      send_char(8'h78);
      send_char(CODE_CR);
      send_char(CODE_LF);
      wait_line_drained();
   endtask

   task automatic test_random_lines();
      int sent;
      int len;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         len = ($urandom_range(4) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 20);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(9) == 0) begin
               send_char(random_noise());
               sent++;
            end
            send_char(random_char());
            sent++;
         end
         send_char(CODE_LF);
         sent++;
         if ($urandom_range(9) == 0) wait_line_drained();
      end
      wait_line_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_dropped_codes();
      test_editing_keys();
      test_empty_line();
      test_full_line();
      test_random_lines();
      repeat (20) @(posedge clock);
      fail_count += echo_and_line_due.size();
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: console_line_editor_core.f
rtl/cle_pkg.sv
rtl/cle_line_ram.sv
rtl/cle_ctrl.sv
rtl/console_line_editor_core.sv
tb/console_line_editor_core_test.sv
